@@ rtl/cfrs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfrs_pkg: channel flow routing step package
// Shared constants, item types, unit request/response types and saturation.
// ----------------------------------------------------------------------------
package cfrs_pkg;

  // network size
  localparam int unsigned JUNCTIONS = 16;
  localparam int unsigned NODE_W    = (JUNCTIONS > 1) ? $clog2(JUNCTIONS) : 1;
  localparam int unsigned MAT_DEPTH = JUNCTIONS * JUNCTIONS;
  localparam int unsigned MAT_W     = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

  // accumulator: J terms of a 48-bit floored product
  localparam int unsigned ACC_W = 49 + NODE_W;

  // shared divider operand width (signed)
  localparam int unsigned DIV_W   = 52;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  // function codes
  localparam logic [2:0] FUNC_WR_MAT  = 3'd0;
  localparam logic [2:0] FUNC_WR_NODE = 3'd1;
  localparam logic [2:0] FUNC_CLR     = 3'd2;
  localparam logic [2:0] FUNC_ADD     = 3'd3;
  localparam logic [2:0] FUNC_STEP    = 3'd4;
  localparam logic [2:0] FUNC_PIN     = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 2'd1;

  localparam logic [15:0] TIME_STEP_RST = 16'd60;
  localparam logic [30:0] SLOPE_RST     = 31'd65;

  // 64-bit saturation bounds, held at 66 bits
  localparam logic signed [65:0] I64_MAX = 66'sd9223372036854775807;
  localparam logic signed [65:0] I64_MIN = -66'sd9223372036854775808;
  localparam logic signed [65:0] SA_HI   = 66'sd2305843009213693951;
  localparam logic signed [65:0] SA_LO   = -66'sd2305843009213693952;

  typedef struct packed {
    logic        [2:0]  func;
    logic        [5:0]  row_node;
    logic        [5:0]  column;
    logic signed [31:0] coefficient;
    logic signed [31:0] node_capacity;
    logic signed [31:0] bottom;
    logic signed [31:0] side;
    logic signed [31:0] rough;
    logic signed [31:0] inflow;
  } in_item_t;

  typedef struct packed {
    logic        [5:0]  node;
    logic signed [31:0] flow;
    logic               last;
    logic               fault;
  } res_item_t;

  typedef struct packed {
    logic signed [31:0] cap;
    logic signed [31:0] bottom;
    logic signed [31:0] side;
    logic signed [31:0] rough;
  } node_par_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] num;
    logic signed [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
    logic               dz;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic        start;
    logic [62:0] x;
  } cbrt_req_t;

  typedef struct packed {
    logic        done;
    logic [20:0] c;
  } cbrt_rsp_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic fits;
    fits = (&x[65:31]) | ~(|x[65:31]);
    if (fits) begin
      return x[31:0];
    end else if (x[65]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

@@ rtl/cfrs_ram.sv @@
// ----------------------------------------------------------------------------
// cfrs_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cfrs_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cfrs_div.sv @@
// ----------------------------------------------------------------------------
// cfrs_div: shared signed divider
// Restoring, one quotient bit per cycle; truncates toward zero, saturates
// to 32 bits, flags a zero divisor.
// ----------------------------------------------------------------------------
module cfrs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfrs_pkg::div_req_t req_i,
  output cfrs_pkg::div_rsp_t rsp_o
);
  import cfrs_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 neg_q;
  logic [DIV_W-1:0]     nq_q;   // numerator bits out, quotient bits in
  logic [DIV_W-1:0]     dmag_q;
  logic [DIV_W:0]       rem_q;
  div_rsp_t             rsp_q;

  logic [DIV_W-1:0]     nmag;
  logic [DIV_W-1:0]     dmag;
  logic [DIV_W:0]       rem_sh;
  logic                 qbit;
  logic [DIV_W:0]       rem_nx;
  logic [DIV_W-1:0]     qnew;
  logic signed [DIV_W:0] qsig;

  always_comb begin
    nmag   = req_i.num[DIV_W-1] ? DIV_W'(-req_i.num) : DIV_W'(req_i.num);
    dmag   = req_i.den[DIV_W-1] ? DIV_W'(-req_i.den) : DIV_W'(req_i.den);
    rem_sh = {rem_q[DIV_W-1:0], nq_q[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dmag_q});
    rem_nx = qbit ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
    qnew   = {nq_q[DIV_W-2:0], qbit};
    qsig   = neg_q ? -$signed({1'b0, qnew}) : $signed({1'b0, qnew});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      nq_q   <= '0;
      dmag_q <= '0;
      rem_q  <= '0;
      rsp_q  <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      if (req_i.start) begin
        neg_q     <= req_i.num[DIV_W-1] ^ req_i.den[DIV_W-1];
        nq_q      <= nmag;
        dmag_q    <= dmag;
        rem_q     <= '0;
        cnt_q     <= DIV_CNT_W'(DIV_W);
        rsp_q.dz  <= (req_i.den == '0);
        if (req_i.den == '0) begin
          rsp_q.done <= 1'b1;
          rsp_q.quo  <= '0;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= rem_nx;
        nq_q  <= qnew;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q     <= 1'b0;
          rsp_q.done <= 1'b1;
          rsp_q.quo  <= sat32(66'(qsig));
        end
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ rtl/cfrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// cfrs_sqrt: floor integer square root
// 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfrs_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfrs_pkg::sqrt_req_t req_i,
  output cfrs_pkg::sqrt_rsp_t rsp_o
);
  import cfrs_pkg::*;

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] x_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic        done_q;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;

  always_comb begin
    rem_sh = {rem_q[32:0], x_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      rem_q  <= '0;
      root_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        x_q    <= req_i.rad;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        x_q    <= {x_q[61:0], 2'b00};
        rem_q  <= take ? 34'(rem_sh - trial) : 34'(rem_sh);
        root_q <= {root_q[30:0], take};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

@@ rtl/cfrs_cbrt.sv @@
// ----------------------------------------------------------------------------
// cfrs_cbrt: floor integer cube root
// 63-bit argument, 21-bit root; each root bit takes a square step, then a cube-and-compare step.
// ----------------------------------------------------------------------------
module cfrs_cbrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfrs_pkg::cbrt_req_t req_i,
  output cfrs_pkg::cbrt_rsp_t rsp_o
);
  import cfrs_pkg::*;

  logic        busy_q;
  logic        ph_q;     // 0: square, 1: cube and compare
  logic [4:0]  bit_q;
  logic [62:0] x_q;
  logic [20:0] c_q;
  logic [20:0] t_q;
  logic [41:0] sq_q;
  logic        done_q;

  logic [20:0] t;
  logic [62:0] cube;

  always_comb begin
    t    = c_q | (21'd1 << bit_q);
    cube = 63'(sq_q * t_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      bit_q  <= '0;
      x_q    <= '0;
      c_q    <= '0;
      t_q    <= '0;
      sq_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= 1'b0;
        bit_q  <= 5'd20;
        x_q    <= req_i.x;
        c_q    <= '0;
      end else if (busy_q) begin
        if (!ph_q) begin
          t_q  <= t;
          sq_q <= t * t;
          ph_q <= 1'b1;
        end else begin
          ph_q <= 1'b0;
          if (cube <= x_q) begin
            c_q <= t_q;
          end
          bit_q <= bit_q - 1'b1;
          if (bit_q == 5'd0) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.c    = c_q;

endmodule

@@ rtl/channel_flow_routing_step_core.sv @@
// ----------------------------------------------------------------------------
// channel_flow_routing_step_core: channel flow routing step
// Lumped finite-element channel routing with Manning's law, Q16.16.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low; busy then
// stays high until the item is done. Loads (matrix entry, node entry, inflow,
// pin, forcing clear) pass through a dispatch state, inflow and pin through a
// write state as well. A step first takes the square root of the slope, then
// walks the stiffness matrix one entry at a time (RAM read, multiply,
// accumulate), then runs each node through one shared multiplier, the shared
// divider (four quotients), the square-root unit (two roots) and the
// cube-root unit. The step then shows one discharge per node on res_o,
// each for exactly one cycle with res_valid_o high; there is no back-pressure,
// so the receiver must take every transfer as it comes. The fault bit is the
// same on every result of a step. Matrix and node tables must be written before
// a step reads them; area, discharge and forcing start at zero after reset
// through valid bits, so there is no clearing pass. Configuration writes are
// taken at any time (cfg_ready_o is tied high) but belong to idle periods.
// ----------------------------------------------------------------------------
module channel_flow_routing_step_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  cfrs_pkg::in_item_t                  item_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cfrs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  output logic                                res_valid_o,
  output cfrs_pkg::res_item_t                 res_o
);
  import cfrs_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISP, ST_ADD_WR, ST_PIN_WR, ST_SQ_WT,
    ST_MAT_RD, ST_MAT_MUL, ST_MAT_ACC,
    ST_N_RD, ST_N_LD, ST_N_M1, ST_N_M2, ST_N_FS, ST_WT_A,
    ST_N_BB, ST_N_SA, ST_N_RAD, ST_WT_ROOT, ST_DIV_H, ST_WT_H,
    ST_N_SS, ST_SQ_RP, ST_WT_RP, ST_N_HR, ST_DIV_R, ST_WT_R, ST_WT_CB,
    ST_N_CC, ST_N_PR, ST_DIV_V, ST_WT_V, ST_N_QA, ST_N_WB,
    ST_O_RD, ST_O_EM
  } state_e;

  localparam logic [NODE_W-1:0] LAST_IDX = NODE_W'(JUNCTIONS - 1);

  function automatic logic [MAT_W-1:0] mat_addr(input logic [NODE_W-1:0] r,
                                                 input logic [NODE_W-1:0] c);
    return MAT_W'(int'(r) * int'(JUNCTIONS) + int'(c));
  endfunction

  state_e                  state_q;
  in_item_t                item_q;
  logic [15:0]             ts_q;
  logic [30:0]             slope_q;
  logic                    fault_q;
  logic [NODE_W-1:0]       row_q;
  logic [NODE_W-1:0]       col_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [23:0]             rslope_q;
  logic signed [65:0]      p_q;

  logic signed [31:0]      cap_q, b_q, s_q, n_q;
  logic signed [31:0]      area_old_q, diff_q, dterm_q, a_q, head_q, vel_q;
  logic [62:0]             bb_q;
  logic [31:0]             root_q, rp_q;
  logic [20:0]             cr_q;

  logic [JUNCTIONS-1:0]    area_vld_q, flow_vld_q, force_vld_q;

  div_req_t                div_req_q;
  div_rsp_t                div_rsp;
  sqrt_req_t               sqrt_req_q;
  sqrt_rsp_t               sqrt_rsp;
  cbrt_req_t               cbrt_req_q;
  cbrt_rsp_t               cbrt_rsp;

  logic                    res_valid_q;
  res_item_t               res_q;

  // ram ports
  logic                    k_we, k_re;
  logic [MAT_W-1:0]        k_waddr, k_raddr;
  logic [31:0]             k_rd;
  logic                    np_we, np_re;
  node_par_t               np_wd, np_rd;
  logic                    ar_we, ar_re;
  logic [31:0]             ar_wd, ar_rd;
  logic                    fl_we, fl_re;
  logic [NODE_W-1:0]       fl_waddr, fl_raddr;
  logic [31:0]             fl_wd, fl_rd;
  logic                    fo_we, fo_re;
  logic [NODE_W-1:0]       fo_raddr;
  logic [31:0]             fo_wd, fo_rd;
  logic                    su_we, su_re;
  logic [31:0]             su_wd, su_rd;

  logic [NODE_W-1:0]       item_idx;
  logic                    row_ok, col_ok;
  logic signed [31:0]      flow_eff, force_eff, area_eff;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod;
  logic signed [31:0]      fstar;
  logic signed [65:0]      t4, rad_w, rad;
  logic signed [33:0]      hnum;
  logic signed [DIV_W-1:0] rden;
  logic signed [31:0]      flow_new;

  assign item_idx = item_q.row_node[NODE_W-1:0];
  assign row_ok   = ({1'b0, item_q.row_node} < 7'(JUNCTIONS));
  assign col_ok   = ({1'b0, item_q.column} < 7'(JUNCTIONS));

  // entries never written read as zero
  assign flow_eff  = flow_vld_q[(state_q == ST_MAT_MUL) ? col_q : row_q] ?
                     $signed(fl_rd) : 32'sd0;
  assign force_eff = force_vld_q[(state_q == ST_N_LD) ? row_q : item_idx] ?
                     $signed(fo_rd) : 32'sd0;
  assign area_eff  = area_vld_q[row_q] ? $signed(ar_rd) : 32'sd0;

  assign acc_new  = acc_q + ACC_W'(p_q >>> 16);
  assign fstar    = sat32((p_q >>> 16) + 66'(dterm_q));
  assign hnum     = $signed({2'b00, root_q}) - 34'(b_q);
  assign rden     = DIV_W'(b_q) + (DIV_W'(p_q >>> 16) <<< 1);
  assign flow_new = sat32(p_q >>> 16);

  // radicand B*B + 4*S*A, saturated to 64 bits
  always_comb begin
    if (p_q > SA_HI) begin
      t4 = I64_MAX;
    end else if (p_q < SA_LO) begin
      t4 = I64_MIN;
    end else begin
      t4 = p_q <<< 2;
    end
    rad_w = $signed({3'b000, bb_q}) + t4;
    rad   = (rad_w > I64_MAX) ? I64_MAX : rad_w;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MAT_MUL: begin mul_a = 33'($signed(k_rd)); mul_b = 33'(flow_eff); end
      ST_N_M1:    begin mul_a = $signed({17'd0, ts_q}); mul_b = 33'(diff_q); end
      ST_N_M2:    begin mul_a = 33'(cap_q); mul_b = 33'(area_old_q); end
      ST_N_BB:    begin mul_a = 33'(b_q); mul_b = 33'(b_q); end
      ST_N_SA:    begin mul_a = 33'(s_q); mul_b = 33'(a_q); end
      ST_N_SS:    begin mul_a = 33'(s_q); mul_b = 33'(s_q); end
      ST_N_HR:    begin mul_a = 33'(head_q); mul_b = $signed({1'b0, rp_q}); end
      ST_N_CC:    begin mul_a = $signed({12'd0, cr_q}); mul_b = $signed({12'd0, cr_q}); end
      ST_N_PR:    begin mul_a = $signed({7'd0, p_q[41:16]}); mul_b = $signed({9'd0, rslope_q}); end
      ST_N_QA:    begin mul_a = 33'(vel_q); mul_b = 33'(a_q); end
      default:    ;
    endcase
  end
  assign prod = mul_a * mul_b;

  // memory port control
  always_comb begin
    k_we     = (state_q == ST_DISP) && (item_q.func == FUNC_WR_MAT) && row_ok && col_ok;
    k_waddr  = mat_addr(item_idx, item_q.column[NODE_W-1:0]);
    k_re     = (state_q == ST_MAT_RD);
    k_raddr  = mat_addr(row_q, col_q);

    np_we    = (state_q == ST_DISP) && (item_q.func == FUNC_WR_NODE) && row_ok;
    np_wd    = '{cap: item_q.node_capacity, bottom: item_q.bottom,
                 side: item_q.side, rough: item_q.rough};
    np_re    = (state_q == ST_N_RD);

    ar_we    = (state_q == ST_N_WB);
    ar_wd    = a_q;
    ar_re    = (state_q == ST_N_RD);

    fl_we    = (state_q == ST_PIN_WR) || (state_q == ST_N_WB);
    fl_waddr = (state_q == ST_PIN_WR) ? item_idx : row_q;
    fl_wd    = (state_q == ST_PIN_WR) ? force_eff : flow_new;
    fl_re    = (state_q == ST_MAT_RD) || (state_q == ST_O_RD);
    fl_raddr = (state_q == ST_MAT_RD) ? col_q : row_q;

    fo_we    = (state_q == ST_ADD_WR);
    fo_wd    = sat32(66'(force_eff) + 66'(item_q.inflow));
    fo_re    = ((state_q == ST_DISP) && row_ok &&
                ((item_q.func == FUNC_ADD) || (item_q.func == FUNC_PIN))) ||
               (state_q == ST_N_RD);
    fo_raddr = (state_q == ST_N_RD) ? row_q : item_idx;

    su_we    = (state_q == ST_MAT_ACC) && (col_q == LAST_IDX);
    su_wd    = sat32(66'(acc_new));
    su_re    = (state_q == ST_N_RD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      ts_q        <= TIME_STEP_RST;
      slope_q     <= SLOPE_RST;
      fault_q     <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      acc_q       <= '0;
      rslope_q    <= '0;
      p_q         <= '0;
      cap_q       <= '0;
      b_q         <= '0;
      s_q         <= '0;
      n_q         <= '0;
      area_old_q  <= '0;
      diff_q      <= '0;
      dterm_q     <= '0;
      a_q         <= '0;
      head_q      <= '0;
      vel_q       <= '0;
      bb_q        <= '0;
      root_q      <= '0;
      rp_q        <= '0;
      cr_q        <= '0;
      area_vld_q  <= '0;
      flow_vld_q  <= '0;
      force_vld_q <= '0;
      div_req_q   <= '0;
      sqrt_req_q  <= '0;
      cbrt_req_q  <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      div_req_q.start  <= 1'b0;
      sqrt_req_q.start <= 1'b0;
      cbrt_req_q.start <= 1'b0;
      res_valid_q      <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_TIME_STEP: ts_q    <= cfg_data_i[15:0];
          CFG_SLOPE:     slope_q <= cfg_data_i[30:0];
          default:       ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            item_q  <= item_i;
            state_q <= ST_DISP;
          end
        end
        ST_DISP: begin
          state_q <= ST_IDLE;
          unique case (item_q.func)
            FUNC_CLR: force_vld_q <= '0;
            FUNC_ADD: if (row_ok) state_q <= ST_ADD_WR;
            FUNC_PIN: if (row_ok) state_q <= ST_PIN_WR;
            FUNC_STEP: begin
              fault_q          <= 1'b0;
              row_q            <= '0;
              col_q            <= '0;
              acc_q            <= '0;
              sqrt_req_q.start <= 1'b1;
              sqrt_req_q.rad   <= {17'd0, slope_q, 16'd0};
              state_q          <= ST_SQ_WT;
            end
            default: ;
          endcase
        end
        ST_ADD_WR: begin
          force_vld_q[item_idx] <= 1'b1;
          state_q               <= ST_IDLE;
        end
        ST_PIN_WR: begin
          flow_vld_q[item_idx] <= 1'b1;
          state_q              <= ST_IDLE;
        end
        ST_SQ_WT: begin
          if (sqrt_rsp.done) begin
            rslope_q <= sqrt_rsp.root[23:0];
            state_q  <= ST_MAT_RD;
          end
        end
        // matrix-vector product on the discharges before the step
        ST_MAT_RD:  state_q <= ST_MAT_MUL;
        ST_MAT_MUL: begin
          p_q     <= prod;
          state_q <= ST_MAT_ACC;
        end
        ST_MAT_ACC: begin
          state_q <= ST_MAT_RD;
          if (col_q == LAST_IDX) begin
            acc_q <= '0;
            col_q <= '0;
            if (row_q == LAST_IDX) begin
              row_q   <= '0;
              state_q <= ST_N_RD;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end else begin
            acc_q <= acc_new;
            col_q <= col_q + 1'b1;
          end
        end
        // per-node update
        ST_N_RD: state_q <= ST_N_LD;
        ST_N_LD: begin
          cap_q      <= np_rd.cap;
          b_q        <= np_rd.bottom;
          s_q        <= np_rd.side;
          n_q        <= np_rd.rough;
          area_old_q <= area_eff;
          diff_q     <= sat32(66'(force_eff) - 66'($signed(su_rd)));
          state_q    <= ST_N_M1;
        end
        ST_N_M1: begin
          p_q     <= prod;
          state_q <= ST_N_M2;
        end
        ST_N_M2: begin
          dterm_q <= sat32(p_q);
          p_q     <= prod;
          state_q <= ST_N_FS;
        end
        ST_N_FS: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= DIV_W'(fstar) <<< 16;
          div_req_q.den   <= DIV_W'(cap_q);
          state_q         <= ST_WT_A;
        end
        ST_WT_A: begin
          if (div_rsp.done) begin
            a_q     <= div_rsp.quo;
            fault_q <= fault_q | div_rsp.dz;
            state_q <= ST_N_BB;
          end
        end
        ST_N_BB: begin
          p_q     <= prod;
          state_q <= ST_N_SA;
        end
        ST_N_SA: begin
          bb_q    <= p_q[62:0];
          p_q     <= prod;
          state_q <= ST_N_RAD;
        end
        ST_N_RAD: begin
          if (rad > 66'sd0) begin
            sqrt_req_q.start <= 1'b1;
            sqrt_req_q.rad   <= rad[63:0];
            state_q          <= ST_WT_ROOT;
          end else begin
            root_q  <= '0;
            state_q <= ST_DIV_H;
          end
        end
        ST_WT_ROOT: begin
          if (sqrt_rsp.done) begin
            root_q  <= sqrt_rsp.root;
            state_q <= ST_DIV_H;
          end
        end
        ST_DIV_H: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= DIV_W'(hnum) <<< 16;
          div_req_q.den   <= DIV_W'(s_q) <<< 1;
          state_q         <= ST_WT_H;
        end
        ST_WT_H: begin
          if (div_rsp.done) begin
            head_q  <= div_rsp.quo;
            fault_q <= fault_q | div_rsp.dz;
            state_q <= ST_N_SS;
          end
        end
        ST_N_SS: begin
          p_q     <= prod;
          state_q <= ST_SQ_RP;
        end
        ST_SQ_RP: begin
          sqrt_req_q.start <= 1'b1;
          sqrt_req_q.rad   <= p_q[63:0] + 64'h1_0000_0000;
          state_q          <= ST_WT_RP;
        end
        ST_WT_RP: begin
          if (sqrt_rsp.done) begin
            rp_q    <= sqrt_rsp.root;
            state_q <= ST_N_HR;
          end
        end
        ST_N_HR: begin
          p_q     <= prod;
          state_q <= ST_DIV_R;
        end
        ST_DIV_R: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= DIV_W'(a_q) <<< 16;
          div_req_q.den   <= rden;
          state_q         <= ST_WT_R;
        end
        ST_WT_R: begin
          if (div_rsp.done) begin
            fault_q <= fault_q | div_rsp.dz;
            if (div_rsp.quo > 32'sd0) begin
              cbrt_req_q.start <= 1'b1;
              cbrt_req_q.x     <= {div_rsp.quo[30:0], 32'd0};
              state_q          <= ST_WT_CB;
            end else begin
              cr_q    <= '0;
              state_q <= ST_N_CC;
            end
          end
        end
        ST_WT_CB: begin
          if (cbrt_rsp.done) begin
            cr_q    <= cbrt_rsp.c;
            state_q <= ST_N_CC;
          end
        end
        ST_N_CC: begin
          p_q     <= prod;
          state_q <= ST_N_PR;
        end
        ST_N_PR: begin
          p_q     <= prod;
          state_q <= ST_DIV_V;
        end
        ST_DIV_V: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= DIV_W'(p_q >>> 16) <<< 16;
          div_req_q.den   <= DIV_W'(n_q);
          state_q         <= ST_WT_V;
        end
        ST_WT_V: begin
          if (div_rsp.done) begin
            vel_q   <= div_rsp.quo;
            fault_q <= fault_q | div_rsp.dz;
            state_q <= ST_N_QA;
          end
        end
        ST_N_QA: begin
          p_q     <= prod;
          state_q <= ST_N_WB;
        end
        ST_N_WB: begin
          area_vld_q[row_q] <= 1'b1;
          flow_vld_q[row_q] <= 1'b1;
          if (row_q == LAST_IDX) begin
            row_q   <= '0;
            state_q <= ST_O_RD;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= ST_N_RD;
          end
        end
        // result transfers, a read state then an emit state per node
        ST_O_RD: state_q <= ST_O_EM;
        ST_O_EM: begin
          res_valid_q <= 1'b1;
          res_q.node  <= 6'(row_q);
          res_q.flow  <= flow_eff;
          res_q.last  <= (row_q == LAST_IDX);
          res_q.fault <= fault_q;
          if (row_q == LAST_IDX) begin
            row_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= ST_O_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // state memories
  cfrs_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_stiff (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(item_q.coefficient),
    .re_i(k_re), .raddr_i(k_raddr), .rdata_o(k_rd)
  );

  cfrs_ram #(.WIDTH($bits(node_par_t)), .DEPTH(JUNCTIONS)) u_node (
    .clk_i, .we_i(np_we), .waddr_i(item_idx), .wdata_i(np_wd),
    .re_i(np_re), .raddr_i(row_q), .rdata_o(np_rd)
  );

  cfrs_ram #(.WIDTH(32), .DEPTH(JUNCTIONS)) u_area (
    .clk_i, .we_i(ar_we), .waddr_i(row_q), .wdata_i(ar_wd),
    .re_i(ar_re), .raddr_i(row_q), .rdata_o(ar_rd)
  );

  cfrs_ram #(.WIDTH(32), .DEPTH(JUNCTIONS)) u_flow (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wd),
    .re_i(fl_re), .raddr_i(fl_raddr), .rdata_o(fl_rd)
  );

  cfrs_ram #(.WIDTH(32), .DEPTH(JUNCTIONS)) u_force (
    .clk_i, .we_i(fo_we), .waddr_i(item_idx), .wdata_i(fo_wd),
    .re_i(fo_re), .raddr_i(fo_raddr), .rdata_o(fo_rd)
  );

  cfrs_ram #(.WIDTH(32), .DEPTH(JUNCTIONS)) u_sum (
    .clk_i, .we_i(su_we), .waddr_i(row_q), .wdata_i(su_wd),
    .re_i(su_re), .raddr_i(row_q), .rdata_o(su_rd)
  );

  // arithmetic units
  cfrs_div u_div (
    .clk_i, .rst_ni, .req_i(div_req_q), .rsp_o(div_rsp)
  );

  cfrs_sqrt u_sqrt (
    .clk_i, .rst_ni, .req_i(sqrt_req_q), .rsp_o(sqrt_rsp)
  );

  cfrs_cbrt u_cbrt (
    .clk_i, .rst_ni, .req_i(cbrt_req_q), .rsp_o(cbrt_rsp)
  );

endmodule

@@ dv/channel_flow_routing_step_core_tb.sv @@
// ----------------------------------------------------------------------------
// channel_flow_routing_step_core_tb: channel routing step testbench
// Drives load, forcing, pin and step commands plus register writes, predicts
// every node's discharge with a local fixed-point network model and checks
// each result transfer in order, under random sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module channel_flow_routing_step_core_tb;
  import cfrs_pkg::*;

  localparam int NJ = JUNCTIONS;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint L64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint L64_MIN = 64'sh8000_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_item_t              item_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [31:0]           cfg_data_i;
  logic                  res_valid_o;
  res_item_t             res_o;

  channel_flow_routing_step_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---- network model state ------------------------------------------------
  longint    stiff_m [NJ][NJ];
  longint    cap_m [NJ];
  longint    bot_m [NJ];
  longint    side_m [NJ];
  longint    rough_m [NJ];
  longint    area_m [NJ];
  longint    dis_m [NJ];
  longint    force_m [NJ];
  longint    step_secs;
  longint    slope_q;

  res_item_t discharge_q[$];   // expected discharges, oldest first
  int        mismatches;
  bit        failed;
  int        quiet_cycles;
  bit        no_gaps;          // long stretch with no sender idling

  function automatic longint clamp32(input longint x);
    if (x > I32_MAX) return I32_MAX;
    if (x < I32_MIN) return I32_MIN;
    return x;
  endfunction

  // Q16.16 product tail: shift right 16, floor
  function automatic longint fl16(input longint x);
    return x >>> 16;
  endfunction

  function automatic longint unsigned root2(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root3(input longint unsigned x);
    longint unsigned c, t;
    c = 0;
    for (int b = 20; b >= 0; b--) begin
      t = c | (64'd1 << b);
      if (t * t * t <= x) c = t;
    end
    return c;
  endfunction

  // zero divisor yields 0 and raises the step's fault
  function automatic longint qdiv(input longint num, input longint den, inout bit dz);
    if (den == 0) begin
      dz = 1'b1;
      return 0;
    end
    return clamp32((num * 65536) / den);
  endfunction

  function automatic void reset_network();
    for (int r = 0; r < NJ; r++) begin
      area_m[r] = 0;
      dis_m[r] = 0;
      force_m[r] = 0;
    end
    step_secs = 60;
    slope_q = 65;
  endfunction

  // explicit update of every node, queues one discharge per node
  function automatic void route_step();
    longint sum [NJ];
    longint acc, rslope, cap, b, s, n, a, bb, sa, t4, rad, root, head, rp, den, hmr;
    longint pw, vel, fstar;
    longint unsigned cr;
    bit dz;
    res_item_t e;
    dz = 1'b0;
    for (int r = 0; r < NJ; r++) begin
      acc = 0;
      for (int c = 0; c < NJ; c++) acc += fl16(stiff_m[r][c] * dis_m[c]);
      sum[r] = clamp32(acc);
    end
    rslope = longint'(root2(longint'(slope_q) * 65536));
    for (int r = 0; r < NJ; r++) begin
      cap = cap_m[r];
      b = bot_m[r];
      s = side_m[r];
      n = rough_m[r];
      fstar = clamp32(fl16(cap * area_m[r]) +
                      clamp32(step_secs * clamp32(force_m[r] - sum[r])));
      a = qdiv(fstar, cap, dz);
      bb = b * b;
      sa = s * a;
      if (sa > L64_MAX / 4) t4 = L64_MAX;
      else if (sa < L64_MIN / 4) t4 = L64_MIN;
      else t4 = sa * 4;
      rad = (t4 > L64_MAX - bb) ? L64_MAX : bb + t4;
      root = (rad > 0) ? longint'(root2(rad)) : 0;
      head = qdiv(root - b, 2 * s, dz);
      rp = longint'(root2(longint'(s * s) + (64'd1 << 32)));
      den = b + 2 * fl16(head * rp);
      hmr = qdiv(a, den, dz);
      pw = 0;
      if (hmr > 0) begin
        cr = root3(longint'(hmr) << 32);
        pw = longint'((cr * cr) >> 16);
      end
      vel = qdiv(fl16(pw * rslope), n, dz);
      area_m[r] = a;
      dis_m[r] = clamp32(fl16(vel * a));
    end
    for (int r = 0; r < NJ; r++) begin
      e.node = 6'(r);
      e.flow = 32'(dis_m[r]);
      e.last = (r == NJ - 1);
      e.fault = dz;
      discharge_q.push_back(e);
    end
  endfunction

  function automatic void apply_item(input in_item_t it);
    int rn, cl;
    rn = it.row_node;
    cl = it.column;
    case (it.func)
      FUNC_WR_MAT: begin
        if (rn < NJ && cl < NJ) stiff_m[rn][cl] = it.coefficient;
      end
      FUNC_WR_NODE: begin
        if (rn < NJ) begin
          cap_m[rn] = it.node_capacity;
          bot_m[rn] = it.bottom;
          side_m[rn] = it.side;
          rough_m[rn] = it.rough;
        end
      end
      FUNC_CLR: begin
        for (int r = 0; r < NJ; r++) force_m[r] = 0;
      end
      FUNC_ADD: begin
        if (rn < NJ) force_m[rn] = clamp32(force_m[rn] + longint'(it.inflow));
      end
      FUNC_PIN: begin
        if (rn < NJ) dis_m[rn] = force_m[rn];
      end
      FUNC_STEP: route_step();
      default: ;
    endcase
  endfunction

  // ---- result checker: no back-pressure, so compare every strobe ---------
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (discharge_q.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", res_o);
      end else begin
        if (res_o.node !== discharge_q[0].node || res_o.flow !== discharge_q[0].flow ||
            res_o.last !== discharge_q[0].last || res_o.fault !== discharge_q[0].fault) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("discharge mismatch: exp node %0d flow %0d last %0b fault %0b, act node %0d flow %0d last %0b fault %0b",
                     discharge_q[0].node, discharge_q[0].flow, discharge_q[0].last,
                     discharge_q[0].fault, res_o.node, res_o.flow, res_o.last, res_o.fault);
        end
        void'(discharge_q.pop_front());
      end
    end
  end

  // watchdog: cycles with no transfer in either direction
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("channel_flow_routing_step_core_tb: FAIL");
      $finish;
    end
  end

  // ---- stimulus helpers ---------------------------------------------------

  // one command transfer; start is left high unless a gap follows
  task automatic send_cmd(input in_item_t it);
    int gap;
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    apply_item(it);
    gap = 0;
    if (!no_gaps && $urandom_range(99) < 38) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for the block to drain before touching registers
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    wait (discharge_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TIME_STEP) step_secs = val[15:0];
    else if (idx == CFG_SLOPE) slope_q = val[30:0];
    cfg_valid_i <= 1'b0;
  endtask

  // mostly hydraulically sensible Q16.16 values, with extremes and full noise
  function automatic logic [31:0] pick_q(input int lo, input int hi);
    int k;
    k = $urandom_range(9);
    if (k < 6) return 32'($urandom_range(hi, lo));
    if (k == 6) return 32'h7FFF_FFFF;
    if (k == 7) return 32'h8000_0000;
    if (k == 8) return 32'h0;
    return $urandom;
  endfunction

  function automatic in_item_t blank_item(input logic [2:0] f);
    in_item_t it;
    it = '0;
    it.func = f;
    return it;
  endfunction

  function automatic in_item_t node_item(input int r, input logic [31:0] c,
      input logic [31:0] b, input logic [31:0] s, input logic [31:0] n);
    in_item_t it;
    it = blank_item(FUNC_WR_NODE);
    it.row_node = 6'(r);
    it.node_capacity = c;
    it.bottom = b;
    it.side = s;
    it.rough = n;
    it.coefficient = $urandom;
    it.inflow = $urandom;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int k;
    it.func = FUNC_WR_MAT;
    it.row_node = 6'($urandom_range(NJ - 1));
    it.column = 6'($urandom_range(NJ - 1));
    if ($urandom_range(9) == 0) it.row_node = 6'($urandom);
    if ($urandom_range(9) == 0) it.column = 6'($urandom);
    it.coefficient = pick_q(-32768, 32768);
    it.node_capacity = pick_q(16384, 262144);
    it.bottom = pick_q(0, 655360);
    it.side = pick_q(0, 196608);
    it.rough = pick_q(1311, 6554);
    it.inflow = pick_q(-65536, 655360);
    k = $urandom_range(99);
    if (k < 20) it.func = FUNC_WR_MAT;
    else if (k < 35) it.func = FUNC_WR_NODE;
    else if (k < 40) it.func = FUNC_CLR;
    else if (k < 70) it.func = FUNC_ADD;
    else if (k < 82) it.func = FUNC_STEP;
    else if (k < 94) it.func = FUNC_PIN;
    else if (k < 97) it.func = FUNC_SPARE_6;
    else it.func = FUNC_SPARE_7;
    return it;
  endfunction

  // ---- tests --------------------------------------------------------------

  // every matrix and node entry is written before any step reads it
  task automatic test_load_tables();
    in_item_t it;
    for (int r = 0; r < NJ; r++)
      for (int c = 0; c < NJ; c++) begin
        it = blank_item(FUNC_WR_MAT);
        it.row_node = 6'(r);
        it.column = 6'(c);
        it.coefficient = (r == c) ? 32'sd65536 :
                         ((c == r - 1) ? -32'sd65536 : 32'sd0);
        send_cmd(it);
      end
    for (int r = 0; r < NJ; r++)
      send_cmd(node_item(r, 32'sd65536, 32'sd196608, 32'sd65536, 32'sd2621));
  endtask

  task automatic test_directed();
    in_item_t it;
    // inflow with extremes, saturating forcing
    it = blank_item(FUNC_ADD);
    it.row_node = 6'd0; it.inflow = 32'sd655360; send_cmd(it);
    it.row_node = 6'd1; it.inflow = 32'h7FFF_FFFF; send_cmd(it);
    send_cmd(it);
    it.row_node = 6'd2; it.inflow = 32'h8000_0000; send_cmd(it);
    send_cmd(it);
    // out-of-range indexes do nothing
    it.row_node = 6'd63; send_cmd(it);
    it = blank_item(FUNC_WR_MAT);
    it.row_node = 6'd0; it.column = 6'd63; it.coefficient = 32'h7FFF_FFFF; send_cmd(it);
    it.row_node = 6'd63; it.column = 6'd0; send_cmd(it);
    send_cmd(node_item(63, 0, 0, 0, 0));
    it = blank_item(FUNC_PIN); it.row_node = 6'd63; send_cmd(it);
    // unused functions
    send_cmd(blank_item(FUNC_SPARE_6));
    send_cmd(blank_item(FUNC_SPARE_7));
    send_cmd(blank_item(FUNC_STEP));
    // pin: discharge taken from forcing
    it = blank_item(FUNC_PIN); it.row_node = 6'd0; send_cmd(it);
    it.row_node = 6'd1; send_cmd(it);
    // zero capacitance, zero side slope, zero roughness: faults
    send_cmd(node_item(3, 0, 32'sd65536, 32'sd65536, 32'sd2621));
    send_cmd(blank_item(FUNC_STEP));
    send_cmd(node_item(3, 32'sd65536, 32'sd65536, 0, 32'sd2621));
    send_cmd(node_item(4, 32'sd65536, 32'sd65536, 32'sd65536, 0));
    send_cmd(blank_item(FUNC_STEP));
    // negative width, side and capacitance at the extremes
    send_cmd(node_item(3, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_cmd(node_item(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_cmd(blank_item(FUNC_STEP));
    send_cmd(blank_item(FUNC_CLR));
    send_cmd(blank_item(FUNC_STEP));
  endtask

  task automatic test_registers();
    in_item_t it;
    logic [31:0] vals [4];
    vals[0] = 32'd1;
    vals[1] = 32'hFFFF_FFFF;
    vals[2] = 32'd600;
    vals[3] = 32'd60;
    for (int i = 0; i < 4; i++) begin
      wait_idle();
      write_reg(CFG_TIME_STEP, vals[i]);
      write_reg(CFG_SLOPE, (i == 1) ? 32'hFFFF_FFFF : ((i == 0) ? 32'd0 : $urandom));
      write_reg(CFG_SPARE_2, $urandom);
      write_reg(CFG_SPARE_3, $urandom);
      it = blank_item(FUNC_ADD);
      it.row_node = 6'(i);
      it.inflow = 32'sd131072;
      send_cmd(it);
      send_cmd(blank_item(FUNC_STEP));
    end
  endtask

  // sender holds off until every discharge is back
  task automatic test_drain_pause();
    send_cmd(blank_item(FUNC_STEP));
    wait_idle();
    send_cmd(blank_item(FUNC_STEP));
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_reg(CFG_TIME_STEP, (ph == 3) ? 32'd65535 : 32'($urandom_range(300, 1)));
      write_reg(CFG_SLOPE, (ph == 2) ? 32'h7FFF_FFFF : 32'($urandom_range(6554)));
      no_gaps = (ph == 1);
      for (int i = 0; i < 60; i++) send_cmd(rand_item());
      send_cmd(blank_item(FUNC_STEP));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TIME_STEP;
    cfg_data_i = '0;
    mismatches = 0;
    failed = 1'b0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    reset_network();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_load_tables();
    test_directed();
    test_registers();
    test_drain_pause();
    test_random();

    wait_idle();
    if (!failed) begin
      $display("channel_flow_routing_step_core_tb: PASS");
    end else begin
      $display("channel_flow_routing_step_core_tb: FAIL");
    end
    $finish;
  end

endmodule
